>>> hdl/urq_pkg.sv
package urq_pkg;

    localparam logic [2:0] MODE_TX_PUSH  = 3'd0;
    localparam logic [2:0] MODE_TX_READY = 3'd1;
    localparam logic [2:0] MODE_RX_BYTE  = 3'd2;
    localparam logic [2:0] MODE_RX_POP   = 3'd3;
    localparam logic [2:0] MODE_COMPARE  = 3'd4;
    localparam logic [2:0] MODE_CLR_FLAG = 3'd5;

    localparam logic [1:0] REL_LESS  = 2'd0;
    localparam logic [1:0] REL_EQUAL = 2'd1;
    localparam logic [1:0] REL_MORE  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_stat;

endpackage

>>> hdl/uart_tx_rx_ring_queues_unit.sv
// Channel   Handshake            Payload
// request   i_valid / o_stall    i_mode, i_data_byte, i_compare_size
// result    o_valid / i_stall    o_ok, o_line_send, o_line_byte, o_read_byte,
//                                o_level_relation, o_overflow_flag, o_tx_busy, o_tx_empty
//
// Each request passes through the idle and read states: the accept cycle updates
// the ring pointers and issues the memory access, and the read state takes the
// registered RAM read data. A result waits in the output register; while it is
// stalled a finished request holds in the read state. Synchronous reset clears the
// state, pointers and flags only; the ring memories need no clearing.
module uart_tx_rx_ring_queues_unit
    import urq_pkg::*;
#(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_compare_size,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_ok,
    output logic       o_line_send,
    output logic [7:0] o_line_byte,
    output logic [7:0] o_read_byte,
    output logic [1:0] o_level_relation,
    output logic       o_overflow_flag,
    output logic       o_tx_busy,
    output logic       o_tx_empty
);

    localparam int TPW = $clog2(TX_DEPTH);
    localparam int RPW = $clog2(RX_DEPTH);
    localparam int LW  = RPW + 8;

    t_state r_state;
    t_state n_state;
    logic   s_accept;
    logic   s_load;

    t_ring_stat     tx_stat;
    t_ring_stat     rx_stat;
    logic [TPW-1:0] tx_wptr;
    logic [TPW-1:0] tx_rptr;
    logic [RPW-1:0] rx_wptr;
    logic [RPW-1:0] rx_rptr;
    logic [7:0]     tx_rdata;
    logic [7:0]     rx_rdata;

    logic       tx_push_ok;
    logic       tx_try;
    logic       tx_send;
    logic       rx_push_ok;
    logic       rx_pop_ok;
    logic       req_ok;
    logic [1:0] req_rel;
    logic [RPW:0]   rx_diff;
    logic [RPW-1:0] rx_level;
    logic [LW-1:0]  level_ext;
    logic [LW-1:0]  size_ext;

    logic       r_busy;
    logic       r_dropped;
    logic       r_ok;
    logic       r_send;
    logic       r_fwd;
    logic [7:0] r_fwd_byte;
    logic       r_pop;
    logic [1:0] r_rel;

    logic       r_out_valid;
    logic       r_out_ok;
    logic       r_out_send;
    logic [7:0] r_out_line_byte;
    logic [7:0] r_out_read_byte;
    logic [1:0] r_out_rel;
    logic       r_out_dropped;
    logic       r_out_busy;
    logic       r_out_tx_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_accept = 1'b0;
        s_load   = 1'b0;
        o_stall  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall  = 1'b0;
                s_accept = i_valid;
            end
            ST_READ: begin
                s_load = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign tx_push_ok = s_accept && (i_mode == MODE_TX_PUSH) && !tx_stat.full;
    assign tx_try     = s_accept && (((i_mode == MODE_TX_PUSH) && !r_busy)
                                     || (i_mode == MODE_TX_READY));
    assign tx_send    = tx_try && !(tx_stat.empty && !tx_push_ok);
    assign rx_push_ok = s_accept && (i_mode == MODE_RX_BYTE) && !rx_stat.full;
    assign rx_pop_ok  = s_accept && (i_mode == MODE_RX_POP) && !rx_stat.empty;

    assign rx_diff   = {1'b0, rx_wptr} - {1'b0, rx_rptr};
    assign rx_level  = (rx_wptr >= rx_rptr) ? rx_diff[RPW-1:0]
                     : RPW'(rx_diff + (RPW+1)'(RX_DEPTH));
    assign level_ext = LW'(rx_level);
    assign size_ext  = LW'(i_compare_size);

    always_comb begin
        req_ok  = 1'b0;
        req_rel = REL_LESS;
        case (i_mode)
            MODE_TX_PUSH:  req_ok = tx_push_ok;
            MODE_TX_READY: req_ok = tx_send;
            MODE_RX_BYTE:  req_ok = rx_push_ok;
            MODE_RX_POP:   req_ok = rx_pop_ok;
            MODE_COMPARE: begin
                req_ok = 1'b1;
                if (!rx_stat.empty) begin
                    if (level_ext == size_ext) begin
                        req_rel = REL_EQUAL;
                    end else if (level_ext > size_ext) begin
                        req_rel = REL_MORE;
                    end
                end
            end
            MODE_CLR_FLAG: req_ok = 1'b1;
            default:       req_ok = 1'b0;
        endcase
    end

    urq_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tx_push_ok),
        .i_pop   (tx_send),
        .o_wptr  (tx_wptr),
        .o_rptr  (tx_rptr),
        .o_stat  (tx_stat)
    );

    urq_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rx_push_ok),
        .i_pop   (rx_pop_ok),
        .o_wptr  (rx_wptr),
        .o_rptr  (rx_rptr),
        .o_stat  (rx_stat)
    );

    urq_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_push_ok),
        .i_waddr (tx_wptr),
        .i_wdata (i_data_byte),
        .i_re    (tx_send),
        .i_raddr (tx_rptr),
        .o_rdata (tx_rdata)
    );

    urq_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_push_ok),
        .i_waddr (rx_wptr),
        .i_wdata (i_data_byte),
        .i_re    (rx_pop_ok),
        .i_raddr (rx_rptr),
        .o_rdata (rx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            if (tx_try) begin
                r_busy <= tx_send;
            end
            if (s_accept && (i_mode == MODE_RX_BYTE) && rx_stat.full) begin
                r_dropped <= 1'b1;
            end else if (s_accept && (i_mode == MODE_CLR_FLAG)) begin
                r_dropped <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ok       <= req_ok;
            r_send     <= tx_send;
            r_fwd      <= tx_send && tx_stat.empty;
            r_fwd_byte <= i_data_byte;
            r_pop      <= rx_pop_ok;
            r_rel      <= req_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out_ok        <= r_ok;
            r_out_send      <= r_send;
            r_out_line_byte <= !r_send ? 8'd0 : (r_fwd ? r_fwd_byte : tx_rdata);
            r_out_read_byte <= r_pop ? rx_rdata : 8'd0;
            r_out_rel       <= r_rel;
            r_out_dropped   <= r_dropped;
            r_out_busy      <= r_busy;
            r_out_tx_empty  <= tx_stat.empty;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_out_ok;
    assign o_line_send      = r_out_send;
    assign o_line_byte      = r_out_line_byte;
    assign o_read_byte      = r_out_read_byte;
    assign o_level_relation = r_out_rel;
    assign o_overflow_flag  = r_out_dropped;
    assign o_tx_busy        = r_out_busy;
    assign o_tx_empty       = r_out_tx_empty;

`ifndef SYNTHESIS
    a_idle_tx_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> tx_stat.empty)
        else $error("transmitter idle while the transmit ring holds bytes");

    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_send) |-> o_tx_busy)
        else $error("byte sent while the transmitter reports idle");

    a_load_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_READ))
        else $error("result loaded outside the read state");

    a_ring_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rx_stat.full && rx_stat.empty) && !(tx_stat.full && tx_stat.empty))
        else $error("ring reports full and empty at once");
`endif

endmodule

>>> hdl/urq_ram.sv
module urq_ram
    import urq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/urq_ring.sv
module urq_ring
    import urq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic                     i_pop,
    output logic [$clog2(DEPTH)-1:0] o_wptr,
    output logic [$clog2(DEPTH)-1:0] o_rptr,
    output t_ring_stat               o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;

    assign n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
    assign n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
        end
    end

    assign o_wptr       = r_wptr;
    assign o_rptr       = r_rptr;
    assign o_stat.empty = (r_wptr == r_rptr);
    assign o_stat.full  = (n_wptr == r_rptr);

endmodule
